// ===== sv/tasdq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tasdq_pkg
// Shared types, constants and helpers for the three-axis DDA stepper queue.
// ----------------------------------------------------------------------------
package tasdq_pkg;

	localparam int QUEUE_SLOTS = 16;
	localparam int PTR_W       = $clog2(QUEUE_SLOTS);
	localparam int CNT_W       = (PTR_W > 4) ? PTR_W : 4;
	localparam int MAG_W       = 16;
	localparam int LEN_W       = 16;
	localparam int DELTA_W     = 17;
	localparam int ACC_W       = 33;
	localparam int AXES        = 3;

	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_PUSH  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	typedef logic [PTR_W-1:0] ptr_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// one queued frame, kept as direction and magnitude per axis
	typedef struct packed {
		logic [AXES-1:0]            dir;
		logic [AXES-1:0][MAG_W-1:0] mag;
		logic [LEN_W-1:0]           len;
	} frame_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic clear;
	} q_ctrl_t;

	typedef struct packed {
		logic full;
		logic empty;
		cnt_t count_nx;
	} q_stat_t;

	typedef struct packed {
		logic             load;
		logic             run;
		logic [LEN_W-1:0] len;
	} axis_ctrl_t;

	function automatic ptr_t next_slot(input ptr_t p);
		next_slot = (p == PTR_W'(QUEUE_SLOTS - 1)) ? '0 : p + ptr_t'(1);
	endfunction

	function automatic logic delta_dir(input logic [DELTA_W-1:0] d);
		delta_dir = ~d[DELTA_W-1];
	endfunction

	// magnitude of a signed delta, saturated to the magnitude width
	function automatic logic [MAG_W-1:0] delta_mag(input logic [DELTA_W-1:0] d);
		logic [DELTA_W-1:0] neg;
		neg = ~d + DELTA_W'(1);
		if (!d[DELTA_W-1])
			delta_mag = d[MAG_W-1:0];
		else if (neg[DELTA_W-1])
			delta_mag = '1;
		else
			delta_mag = neg[MAG_W-1:0];
	endfunction

endpackage

// ===== sv/three_axis_stepper_dda_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_axis_stepper_dda_queue
// Frame queue and three-axis DDA step generator.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel (cmd_valid / cmd_stall) carries one word per command:
//   a timer tick, a frame push (three signed deltas and a tick length) or a
//   queue clear. Each command word yields exactly one result word on the
//   result channel (res_valid / res_stall): push acceptance, step pulses,
//   latched directions, busy flag and the number of frames still queued.
//   A command goes from the command register to the result register; one
//   command is taken every cycle unless the result side stalls. The tick
//   path (registered queue head, 33-bit add, compare and subtract per
//   axis) sits between the command register and the result register.
//   A tick on an idle block pops the next frame and runs that tick at once.
//   A clear drops the queued frames but lets a running frame finish.
//   Reset empties the queue, stops any frame and drops both pipeline words;
//   the block takes commands on the first cycle after reset.
//   While res_stall is high on a valid result the result register holds; the
//   command register still takes one more word, after which cmd_stall rises.
// ----------------------------------------------------------------------------
module three_axis_stepper_dda_queue (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cmd_valid,
	output logic                                cmd_stall,
	input  logic [1:0]                          command,
	input  logic signed [tasdq_pkg::DELTA_W-1:0] delta_a,
	input  logic signed [tasdq_pkg::DELTA_W-1:0] delta_b,
	input  logic signed [tasdq_pkg::DELTA_W-1:0] delta_c,
	input  logic [tasdq_pkg::LEN_W-1:0]         frame_ticks,
	output logic                                res_valid,
	input  logic                                res_stall,
	output logic                                accepted,
	output logic                                step_a,
	output logic                                step_b,
	output logic                                step_c,
	output logic                                dir_a,
	output logic                                dir_b,
	output logic                                dir_c,
	output logic                                busy_res,
	output logic [3:0]                          queued_frames
);

	logic                         valid_s1;
	logic [1:0]                   command_s1;
	logic [tasdq_pkg::DELTA_W-1:0] delta_a_s1;
	logic [tasdq_pkg::DELTA_W-1:0] delta_b_s1;
	logic [tasdq_pkg::DELTA_W-1:0] delta_c_s1;
	logic [tasdq_pkg::LEN_W-1:0]  ticks_s1;

	logic                         advance;
	logic                         cmd_take;
	logic                         tick;
	logic                         load;
	logic                         run;
	logic                         running_q;
	logic                         running_nx;
	logic [tasdq_pkg::LEN_W-1:0]  len_q;
	logic [tasdq_pkg::LEN_W-1:0]  len_src;
	logic [tasdq_pkg::LEN_W-1:0]  elapsed_q;
	logic [tasdq_pkg::LEN_W:0]    elapsed_nx;

	tasdq_pkg::q_ctrl_t           q_ctrl;
	tasdq_pkg::q_stat_t           q_stat;
	tasdq_pkg::frame_t            wr_frame;
	tasdq_pkg::frame_t            head;
	tasdq_pkg::axis_ctrl_t        ax_ctrl;
	logic [tasdq_pkg::AXES-1:0]   steps;
	logic [tasdq_pkg::AXES-1:0]   dirs;

	assign advance   = valid_s1 && (!res_valid || !res_stall);
	assign cmd_stall = valid_s1 && !advance;
	assign cmd_take  = cmd_valid && !cmd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (cmd_take)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			command_s1 <= command;
			delta_a_s1 <= delta_a;
			delta_b_s1 <= delta_b;
			delta_c_s1 <= delta_c;
			ticks_s1   <= frame_ticks;
		end
	end

	// queue side
	always_comb begin
		q_ctrl.push  = advance && (command_s1 == tasdq_pkg::CMD_PUSH);
		q_ctrl.clear = advance && (command_s1 == tasdq_pkg::CMD_CLEAR);
		q_ctrl.pop   = load;
		wr_frame.dir = {tasdq_pkg::delta_dir(delta_c_s1), tasdq_pkg::delta_dir(delta_b_s1),
		                tasdq_pkg::delta_dir(delta_a_s1)};
		wr_frame.mag[0] = tasdq_pkg::delta_mag(delta_a_s1);
		wr_frame.mag[1] = tasdq_pkg::delta_mag(delta_b_s1);
		wr_frame.mag[2] = tasdq_pkg::delta_mag(delta_c_s1);
		wr_frame.len = ticks_s1;
	end

	tasdq_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (q_ctrl),
		.wr_frame (wr_frame),
		.head     (head),
		.stat     (q_stat)
	);

	// frame sequencing
	always_comb begin
		tick       = advance && (command_s1 == tasdq_pkg::CMD_TICK);
		load       = tick && !running_q && !q_stat.empty;
		run        = tick && (running_q || load);
		len_src    = load ? head.len : len_q;
		elapsed_nx = (load ? '0 : {1'b0, elapsed_q}) + (tasdq_pkg::LEN_W + 1)'(1);
		running_nx = run ? (elapsed_nx < {1'b0, len_src}) : running_q;
		ax_ctrl.load = load;
		ax_ctrl.run  = run;
		ax_ctrl.len  = len_src;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			len_q     <= '0;
			elapsed_q <= '0;
		end else begin
			running_q <= running_nx;
			if (load)
				len_q <= head.len;
			if (run)
				elapsed_q <= elapsed_nx[tasdq_pkg::LEN_W-1:0];
		end
	end

	for (genvar i = 0; i < tasdq_pkg::AXES; i++) begin : g_axis
		tasdq_axis u_axis (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ax_ctrl),
			.ld_mag (head.mag[i]),
			.ld_dir (head.dir[i]),
			.step   (steps[i]),
			.dir    (dirs[i])
		);
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid <= 1'b0;
		else if (advance)
			res_valid <= 1'b1;
		else if (!res_stall)
			res_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			accepted      <= q_ctrl.push && !q_stat.full;
			step_a        <= steps[0];
			step_b        <= steps[1];
			step_c        <= steps[2];
			dir_a         <= dirs[0];
			dir_b         <= dirs[1];
			dir_c         <= dirs[2];
			busy_res      <= running_nx;
			queued_frames <= q_stat.count_nx[3:0];
		end
	end

	a_push_no_step: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && accepted |-> !(step_a || step_b || step_c))
		else $error("step pulse on a push result");

	a_full_refused: assert property (@(posedge clk) disable iff (!arst_n)
		q_ctrl.push && q_stat.full |=> res_valid && !accepted)
		else $error("push into a full queue was accepted");

	a_stop_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(running_q) |-> $past(run))
		else $error("frame stopped without a tick");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.count_nx <= tasdq_pkg::CNT_W'(tasdq_pkg::QUEUE_SLOTS - 1))
		else $error("queue count exceeds capacity");

endmodule

// ===== sv/tasdq_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tasdq_queue
// Ring FIFO of motion frames; one slot stays free to tell full from empty.
// ----------------------------------------------------------------------------
module tasdq_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  tasdq_pkg::q_ctrl_t  ctrl,
	input  tasdq_pkg::frame_t   wr_frame,
	output tasdq_pkg::frame_t   head,
	output tasdq_pkg::q_stat_t  stat
);

	tasdq_pkg::frame_t slots_q [tasdq_pkg::QUEUE_SLOTS];
	tasdq_pkg::frame_t head_q;
	tasdq_pkg::ptr_t   wr_ptr_q;
	tasdq_pkg::ptr_t   rd_ptr_q;
	tasdq_pkg::ptr_t   wr_ptr_nx;
	tasdq_pkg::ptr_t   rd_ptr_nx;
	tasdq_pkg::cnt_t   wr_ext;
	tasdq_pkg::cnt_t   rd_ext;
	tasdq_pkg::cnt_t   cnt_nx;
	logic              q_full;
	logic              q_empty;
	logic              do_push;
	logic              do_pop;

	assign q_full  = (tasdq_pkg::next_slot(wr_ptr_q) == rd_ptr_q);
	assign q_empty = (wr_ptr_q == rd_ptr_q);
	assign do_push = ctrl.push && !q_full;
	assign do_pop  = ctrl.pop && !q_empty;
	assign head    = head_q;
	assign stat    = '{full: q_full, empty: q_empty, count_nx: cnt_nx};

	always_comb begin
		wr_ptr_nx = wr_ptr_q;
		rd_ptr_nx = rd_ptr_q;
		if (do_push)
			wr_ptr_nx = tasdq_pkg::next_slot(wr_ptr_q);
		if (ctrl.clear)
			rd_ptr_nx = wr_ptr_q;
		else if (do_pop)
			rd_ptr_nx = tasdq_pkg::next_slot(rd_ptr_q);
		wr_ext = tasdq_pkg::CNT_W'(wr_ptr_nx);
		rd_ext = tasdq_pkg::CNT_W'(rd_ptr_nx);
		if (wr_ext >= rd_ext)
			cnt_nx = wr_ext - rd_ext;
		else
			cnt_nx = tasdq_pkg::CNT_W'(tasdq_pkg::QUEUE_SLOTS) - rd_ext + wr_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_nx;
			rd_ptr_q <= rd_ptr_nx;
		end
	end

	// hold the next head word in a register; forward a push into the slot that becomes the head
	always_ff @(posedge clk) begin
		if (do_push)
			slots_q[wr_ptr_q] <= wr_frame;
		if (do_push && (wr_ptr_q == rd_ptr_nx))
			head_q <= wr_frame;
		else
			head_q <= slots_q[rd_ptr_nx];
	end

endmodule

// ===== sv/tasdq_axis.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tasdq_axis
// One DDA axis: magnitude, direction and error accumulator for a frame.
// ----------------------------------------------------------------------------
module tasdq_axis (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tasdq_pkg::axis_ctrl_t         ctrl,
	input  logic [tasdq_pkg::MAG_W-1:0]   ld_mag,
	input  logic                          ld_dir,
	output logic                          step,
	output logic                          dir
);

	logic [tasdq_pkg::MAG_W-1:0] mag_q;
	logic                        dir_q;
	logic [tasdq_pkg::ACC_W-1:0] acc_q;
	logic [tasdq_pkg::ACC_W-1:0] acc_src;
	logic [tasdq_pkg::ACC_W-1:0] sum;
	logic [tasdq_pkg::ACC_W-1:0] len_ext;
	logic [tasdq_pkg::MAG_W-1:0] mag_src;
	logic                        reach;

	always_comb begin
		len_ext = tasdq_pkg::ACC_W'(ctrl.len);
		// a new frame starts half way to the first step
		acc_src = ctrl.load ? tasdq_pkg::ACC_W'(ctrl.len[tasdq_pkg::LEN_W-1:1]) : acc_q;
		mag_src = ctrl.load ? ld_mag : mag_q;
		sum     = acc_src + tasdq_pkg::ACC_W'(mag_src);
		reach   = (sum >= len_ext);
	end

	assign step = ctrl.run && reach;
	assign dir  = ctrl.load ? ld_dir : dir_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mag_q <= '0;
			dir_q <= 1'b0;
			acc_q <= '0;
		end else begin
			if (ctrl.load) begin
				mag_q <= ld_mag;
				dir_q <= ld_dir;
			end
			if (ctrl.run)
				acc_q <= reach ? sum - len_ext : sum;
		end
	end

endmodule

// ===== sim/three_axis_stepper_dda_queue_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_axis_stepper_dda_queue_tb
// Self-checking bench for the three-axis DDA stepper frame queue.
// ----------------------------------------------------------------------------
// Each command word is accepted on the command channel and fed to a behavioral
// copy of the frame queue and interpolator. That copy predicts the result
// word, which is compared field by field with what the block returns. The
// command stream starts with a few hand-picked cases. Random motion bursts,
// queue floods, pushes of long frames that are cleared before they run, and
// stray commands follow. Both sides idle at random, and once the result side
// holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module three_axis_stepper_dda_queue_tb;

	localparam int          CYCLE_LIMIT = 400000;
	localparam int          WORD_TARGET = 1300;
	localparam int          CALM_AFTER  = 1100;
	localparam int          HOLD_AT     = 200;
	localparam int          HOLD_CYCLES = 60;
	localparam int          SLOTS       = tasdq_pkg::QUEUE_SLOTS;
	localparam logic [1:0]  CMD_TICK    = tasdq_pkg::CMD_TICK;
	localparam logic [1:0]  CMD_PUSH    = tasdq_pkg::CMD_PUSH;
	localparam logic [1:0]  CMD_CLEAR   = tasdq_pkg::CMD_CLEAR;
	localparam logic [1:0]  CMD_UNUSED  = 2'd3;

	localparam logic signed [16:0] DELTA_MAX   = 17'sd65535;
	localparam logic signed [16:0] DELTA_MIN   = -17'sd65535;
	localparam logic signed [16:0] DELTA_FLOOR = 17'sh10000;

	typedef struct packed {
		logic       accepted;
		logic [2:0] steps;
		logic [2:0] dirs;
		logic       busy;
		logic [3:0] queued;
	} dda_result_t;

	class dda_scoreboard;
		logic signed [16:0] slot_delta[SLOTS][3];
		logic [15:0]        slot_len[SLOTS];
		int unsigned        wr_slot;
		int unsigned        rd_slot;
		bit                 running;
		logic [16:0]        elapsed;
		logic [15:0]        length;
		logic [15:0]        mag[3];
		logic [32:0]        acc[3];
		logic [2:0]         dirs;
		dda_result_t        pending[$];
		int                 errors;
		int                 checked;
		int                 refused;
		int                 frames_run;
		int                 step_pulses;

		function new();
			wr_slot = 0;
			rd_slot = 0;
			running = 0;
			elapsed = '0;
			length = '0;
			dirs = '0;
			for (int i = 0; i < 3; i++) begin
				mag[i] = '0;
				acc[i] = '0;
			end
			errors = 0;
			checked = 0;
			refused = 0;
			frames_run = 0;
			step_pulses = 0;
		endfunction

		// advance the queue and the interpolator by one accepted word
		function void note_command(input logic [1:0] cmd, input logic signed [16:0] da,
				input logic signed [16:0] db, input logic signed [16:0] dc,
				input logic [15:0] len);
			dda_result_t r;
			int unsigned nx;
			int          v;
			logic [32:0] sum;
			r = '0;
			if (cmd == CMD_PUSH) begin
				nx = (wr_slot + 1) % SLOTS;
				if (nx != rd_slot) begin
					slot_delta[wr_slot][0] = da;
					slot_delta[wr_slot][1] = db;
					slot_delta[wr_slot][2] = dc;
					slot_len[wr_slot] = len;
					wr_slot = nx;
					r.accepted = 1'b1;
				end else begin
					refused++;
				end
			end else if (cmd == CMD_CLEAR) begin
				rd_slot = wr_slot;
			end else if (cmd == CMD_TICK) begin
				if (!running && wr_slot != rd_slot) begin
					length = slot_len[rd_slot];
					elapsed = '0;
					dirs = '0;
					for (int i = 0; i < 3; i++) begin
						v = slot_delta[rd_slot][i];
						if (v < 0) begin
							mag[i] = (v < -65535) ? 16'hFFFF : 16'(-v);
						end else begin
							mag[i] = 16'(v);
							dirs[i] = 1'b1;
						end
						acc[i] = 33'(length >> 1);
					end
					rd_slot = (rd_slot + 1) % SLOTS;
					running = 1;
					frames_run++;
				end
				if (running) begin
					for (int i = 0; i < 3; i++) begin
						sum = acc[i] + 33'(mag[i]);
						if (sum >= 33'(length)) begin
							r.steps[i] = 1'b1;
							sum = sum - 33'(length);
							step_pulses++;
						end
						acc[i] = sum;
					end
					elapsed = elapsed + 17'd1;
					if (elapsed >= 17'(length))
						running = 0;
				end
			end
			r.dirs = dirs;
			r.busy = running;
			r.queued = 4'((wr_slot + SLOTS - rd_slot) % SLOTS);
			pending.push_back(r);
		endfunction

		function void compare(input string name, input logic [3:0] want, input logic [3:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(input dda_result_t got);
			dda_result_t want;
			checked++;
			if (pending.size() == 0) begin
				$error("result word with no command outstanding");
				errors++;
				return;
			end
			want = pending.pop_front();
			compare("accepted", 4'(want.accepted), 4'(got.accepted));
			compare("step_a", 4'(want.steps[0]), 4'(got.steps[0]));
			compare("step_b", 4'(want.steps[1]), 4'(got.steps[1]));
			compare("step_c", 4'(want.steps[2]), 4'(got.steps[2]));
			compare("dir_a", 4'(want.dirs[0]), 4'(got.dirs[0]));
			compare("dir_b", 4'(want.dirs[1]), 4'(got.dirs[1]));
			compare("dir_c", 4'(want.dirs[2]), 4'(got.dirs[2]));
			compare("busy_res", 4'(want.busy), 4'(got.busy));
			compare("queued_frames", want.queued, got.queued);
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               cmd_valid;
	logic               cmd_stall;
	logic [1:0]         command;
	logic signed [16:0] delta_a;
	logic signed [16:0] delta_b;
	logic signed [16:0] delta_c;
	logic [15:0]        frame_ticks;
	logic               res_valid;
	logic               res_stall;
	logic               accepted;
	logic               step_a;
	logic               step_b;
	logic               step_c;
	logic               dir_a;
	logic               dir_b;
	logic               dir_c;
	logic               busy_res;
	logic [3:0]         queued_frames;

	dda_scoreboard sb = new;
	int  words_sent   = 0;
	int  results_seen = 0;
	int  cycles       = 0;
	bit  gaps_on      = 0;
	bit  held_off     = 0;

	three_axis_stepper_dda_queue dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.command(command),
		.delta_a(delta_a),
		.delta_b(delta_b),
		.delta_c(delta_c),
		.frame_ticks(frame_ticks),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.accepted(accepted),
		.step_a(step_a),
		.step_b(step_b),
		.step_c(step_c),
		.dir_a(dir_a),
		.dir_b(dir_b),
		.dir_c(dir_c),
		.busy_res(busy_res),
		.queued_frames(queued_frames)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, sb.pending.size());
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			sb.check_result({accepted, step_c, step_b, step_a, dir_c, dir_b, dir_a,
				busy_res, queued_frames});
			results_seen++;
		end
	end

	// result side: one long hold-off to back the block up, else short random stalls
	initial begin
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!held_off && results_seen >= HOLD_AT) begin
				held_off = 1;
				res_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				res_stall = 1'b0;
			end else if (gaps_on && $urandom_range(0, 7) == 0) begin
				res_stall = 1'b1;
				repeat ($urandom_range(1, 5)) @(negedge clk);
				res_stall = 1'b0;
			end
		end
	end

	// offer one word, hold it until taken
	task automatic send_word(input logic [1:0] cmd, input logic signed [16:0] da,
			input logic signed [16:0] db, input logic signed [16:0] dc,
			input logic [15:0] len);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			cmd_valid = 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		cmd_valid = 1'b1;
		command = cmd;
		delta_a = da;
		delta_b = db;
		delta_c = dc;
		frame_ticks = len;
		do @(posedge clk); while (cmd_stall);
		sb.note_command(cmd, da, db, dc, len);
		words_sent++;
		@(negedge clk);
	endtask

	function automatic logic [15:0] rand_len();
		if ($urandom_range(0, 19) == 0)
			return 16'($urandom_range(17, 300));
		return 16'($urandom_range(0, 16));
	endfunction

	// mix of extremes, full-range values and rates near the frame length
	function automatic logic signed [16:0] rand_delta(input int span);
		int v;
		case ($urandom_range(0, 9))
			0: return DELTA_MAX;
			1: return DELTA_MIN;
			2: return DELTA_FLOOR;
			3: return '0;
			4, 5: return 17'($urandom);
			default: begin
				v = $urandom_range(0, span + 1);
				return ($urandom_range(0, 1) != 0) ? 17'(v) : 17'(-v);
			end
		endcase
	endfunction

	// any command with an arbitrary payload; pushes keep a short length
	task automatic send_stray();
		logic [1:0] cmd;
		cmd = 2'($urandom_range(0, 3));
		send_word(cmd, 17'($urandom), 17'($urandom), 17'($urandom),
			(cmd == CMD_PUSH) ? rand_len() : 16'($urandom));
	endtask

	initial begin
		int          nframes;
		int          span;
		int          pick;
		logic [15:0] len;

		arst_n = 1'b0;
		cmd_valid = 1'b0;
		command = CMD_TICK;
		delta_a = '0;
		delta_b = '0;
		delta_c = '0;
		frame_ticks = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// idle tick, clear and unused command on an empty queue
		send_word(CMD_TICK, '0, '0, '0, '0);
		send_word(CMD_CLEAR, '0, '0, '0, '0);
		send_word(CMD_UNUSED, DELTA_MAX, DELTA_MAX, DELTA_MAX, 16'hFFFF);
		// zero-length frame with extreme deltas, including the saturating one
		send_word(CMD_PUSH, DELTA_MAX, DELTA_MIN, DELTA_FLOOR, 16'd0);
		send_word(CMD_TICK, '0, '0, '0, '0);
		// clear behind a running frame drops only the queued one
		send_word(CMD_PUSH, 17'sd0, 17'sd1, -17'sd1, 16'd3);
		send_word(CMD_TICK, '0, '0, '0, '0);
		send_word(CMD_PUSH, DELTA_MAX, DELTA_FLOOR, DELTA_MIN, 16'hFFFF);
		send_word(CMD_CLEAR, '0, '0, '0, '0);
		repeat (3) send_word(CMD_TICK, '0, '0, '0, '0);
		send_word(CMD_PUSH, 17'sh0AAAA, 17'sh15555, 17'sh1FFFF, 16'hAAAA);
		send_word(CMD_PUSH, 17'sh15555, 17'sh0AAAA, 17'sh00000, 16'h5555);
		send_word(CMD_CLEAR, '0, '0, '0, '0);
		send_word(CMD_PUSH, DELTA_MAX, DELTA_MAX, DELTA_MAX, 16'd1);
		send_word(CMD_TICK, '0, '0, '0, '0);
		send_word(CMD_PUSH, 17'sd5, -17'sd3, 17'sd2, 16'd7);
		repeat (8) send_word(CMD_TICK, '0, '0, '0, '0);

		gaps_on = 1;
		while (words_sent < WORD_TARGET) begin
			if (words_sent >= CALM_AFTER)
				gaps_on = 0;
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				// motion burst; sometimes cut short so frames carry over
				nframes = $urandom_range(1, 4);
				span = 0;
				for (int k = 0; k < nframes; k++) begin
					len = rand_len();
					span += (len == 0) ? 1 : int'(len);
					send_word(CMD_PUSH, rand_delta(int'(len)), rand_delta(int'(len)),
						rand_delta(int'(len)), len);
				end
				if ($urandom_range(0, 3) == 0)
					span = span / 2;
				else
					span += $urandom_range(0, 3);
				repeat (span) begin
					if (words_sent >= WORD_TARGET)
						break;
					if ($urandom_range(0, 15) == 0)
						send_stray();
					send_word(CMD_TICK, '0, '0, '0, '0);
				end
			end else if (pick < 70) begin
				// flood up to or past full, then drain or drop
				nframes = $urandom_range(14, 18);
				span = 0;
				for (int k = 0; k < nframes; k++) begin
					len = 16'($urandom_range(0, 3));
					span += (len == 0) ? 1 : int'(len);
					send_word(CMD_PUSH, rand_delta(int'(len)), rand_delta(int'(len)),
						rand_delta(int'(len)), len);
				end
				if ($urandom_range(0, 1) == 0)
					send_word(CMD_CLEAR, '0, '0, '0, '0);
				else
					repeat (span + 1) send_word(CMD_TICK, '0, '0, '0, '0);
			end else if (pick < 80) begin
				// long frames that never run
				nframes = $urandom_range(1, 3);
				for (int k = 0; k < nframes; k++)
					send_word(CMD_PUSH, 17'($urandom), 17'($urandom), 17'($urandom),
						16'($urandom));
				send_word(CMD_CLEAR, '0, '0, '0, '0);
			end else begin
				repeat ($urandom_range(1, 6)) send_stray();
			end
		end
		cmd_valid = 1'b0;
		gaps_on = 0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("%0d command words, %0d results checked, %0d frames run",
			words_sent, sb.checked, sb.frames_run);
		$display("%0d step pulses predicted, %0d pushes refused on a full queue",
			sb.step_pulses, sb.refused);
		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
